@@ rtl/gts_pkg.sv @@
// Shared types, register codes and widths of the Gouraud triangle setup block.
package gts_pkg;

    localparam int COORD_W   = 11;
    localparam int RGB_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int CFRAC     = 15;
    localparam int FX_SHIFT  = 16;
    localparam int COL_W     = CHAN_W + CFRAC;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int FXD_W     = DIFF_W + FX_SHIFT;
    localparam int NUM_W     = 34;
    localparam int NUMS_W    = NUM_W + 2;
    localparam int DEN_W     = 24;
    localparam int DENS_W    = DEN_W + 1;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 5;
    localparam int WRITES    = 20;
    localparam int PADDR_W   = 3;

    localparam logic [IDX_W-1:0] REG_RSTART      = 5'd0;
    localparam logic [IDX_W-1:0] REG_GSTART      = 5'd1;
    localparam logic [IDX_W-1:0] REG_BSTART      = 5'd2;
    localparam logic [IDX_W-1:0] REG_DRDY_DOM    = 5'd3;
    localparam logic [IDX_W-1:0] REG_DGDY_DOM    = 5'd4;
    localparam logic [IDX_W-1:0] REG_DBDY_DOM    = 5'd5;
    localparam logic [IDX_W-1:0] REG_DRDX        = 5'd6;
    localparam logic [IDX_W-1:0] REG_DGDX        = 5'd7;
    localparam logic [IDX_W-1:0] REG_DBDX        = 5'd8;
    localparam logic [IDX_W-1:0] REG_START_X_DOM = 5'd9;
    localparam logic [IDX_W-1:0] REG_DX_DOM      = 5'd10;
    localparam logic [IDX_W-1:0] REG_START_X_SUB = 5'd11;
    localparam logic [IDX_W-1:0] REG_DX_SUB      = 5'd12;
    localparam logic [IDX_W-1:0] REG_START_Y     = 5'd13;
    localparam logic [IDX_W-1:0] REG_DY          = 5'd14;
    localparam logic [IDX_W-1:0] REG_COUNT       = 5'd15;
    localparam logic [IDX_W-1:0] REG_RENDER      = 5'd16;
    localparam logic [IDX_W-1:0] REG_CONTINUE    = 5'd17;

    // Write slots past the first seventeen, which carry the lower sub edge.
    localparam logic [IDX_W-1:0] SLOT_SUB_X2     = 5'd17;
    localparam logic [IDX_W-1:0] SLOT_SUB_DX2    = 5'd18;
    localparam logic [IDX_W-1:0] SLOT_COUNT2     = 5'd19;

    localparam logic [PADDR_W-1:0] ADDR_RENDER_CMD = 3'd0;

    typedef struct packed {
        logic [COORD_W-1:0] vert0_x;
        logic [COORD_W-1:0] vert0_y;
        logic [RGB_W-1:0]   vert0_rgb;
        logic [COORD_W-1:0] vert1_x;
        logic [COORD_W-1:0] vert1_y;
        logic [RGB_W-1:0]   vert1_rgb;
        logic [COORD_W-1:0] vert2_x;
        logic [COORD_W-1:0] vert2_y;
        logic [RGB_W-1:0]   vert2_rgb;
    } t_tri;

    typedef struct packed {
        logic [IDX_W-1:0]        reg_index;
        logic signed [VAL_W-1:0] reg_value;
        logic                    last_write;
        logic                    setup_error;
    } t_wr;

    // Register written by each write slot.
    function automatic logic [IDX_W-1:0] gts_reg_index(input logic [IDX_W-1:0] slot);
        logic [IDX_W-1:0] idx;
        case (slot)
            SLOT_SUB_X2:  idx = REG_START_X_SUB;
            SLOT_SUB_DX2: idx = REG_DX_SUB;
            SLOT_COUNT2:  idx = REG_CONTINUE;
            default:      idx = slot;
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/gouraud_triangle_setup_top.sv @@
// Top level of the Gouraud triangle setup block: front stages, write sequencer, divider pipe.
//
//  Channel   Direction  Signals                                    Beat
//  triangle  in         i_valid, o_stall, i_tri                    one sorted triangle
//  writes    out        o_valid, i_stall, o_wr                     one register write
//  config    in         psel, penable, pwrite, paddr, pwdata,     render command
//                       prdata, pready
//
// A triangle beat yields twenty write beats; while the write side does not stall, the
// write sequencer issues one divide or pass-through per cycle, one write beat each, and
// takes a new triangle only after its last write. A rejected triangle yields one error beat.
// From triangle beat to first write beat the path runs through three front stages, the
// sequencer, one operand stage and a 34-stage restoring divider, then the output register.
// Reset is synchronous and clears only valid bits, the slot counter and the render command.
// A stall on the write side freezes the sequencer and divider pipe in place; the front
// stages keep filling until they hold a triangle each, then the triangle side is stalled.
module gouraud_triangle_setup_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  gts_pkg::t_tri                 i_tri,
    output logic                          o_valid,
    input  logic                          i_stall,
    output gts_pkg::t_wr                  o_wr,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gts_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import gts_pkg::*;

    // Stage two: coordinates, colors and the two area products.
    typedef struct packed {
        logic [COORD_W-1:0]     x1, x2, x3, y1, y2, y3;
        logic [RGB_W-1:0]       rgb0, rgb1, rgb2;
        logic signed [2*DIFF_W-1:0] p1, p2;
        logic                   order_bad;
    } t_s2;

    // Stage three and the sequencer: everything the twenty writes need.
    typedef struct packed {
        logic                     err;
        logic [2:0][COL_W-1:0]    col;
        logic [2:0][NUMS_W-1:0]   num_dy;
        logic [2:0][NUMS_W-1:0]   num_t1;
        logic [2:0][NUMS_W-1:0]   num_t2;
        logic signed [DENS_W-1:0] area;
        logic signed [DIFF_W-1:0] dy31, dy21, dy32;
        logic [COORD_W-1:0]       x1, x2, y1;
        logic signed [FXD_W-1:0]  fxd31, fxd21, fxd32;
    } t_s3;

    // One operation handed to the divider pipe.
    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         idx;
        logic                     last;
        logic                     err;
        logic                     isdiv;
        logic signed [VAL_W-1:0]  pass;
        logic signed [NUMS_W-1:0] numa;
        logic signed [NUMS_W-1:0] numb;
        logic signed [DENS_W-1:0] den;
    } t_op;

    // One divider stage: two lanes sharing a divisor.
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic                    last;
        logic                    err;
        logic                    isdiv;
        logic signed [VAL_W-1:0] pass;
        logic                    neg_a;
        logic                    neg_b;
        logic [DEN_W-1:0]        den;
        logic [DEN_W-1:0]        rem_a;
        logic [NUM_W-1:0]        nq_a;
        logic [DEN_W-1:0]        rem_b;
        logic [NUM_W-1:0]        nq_b;
    } t_dst;

    localparam logic [IDX_W-1:0] K_LAST = IDX_W'(WRITES - 1);

    // One restoring step: shift in a dividend bit, subtract when it fits.
    function automatic logic [DEN_W+NUM_W-1:0] lane_step(input logic [DEN_W-1:0] rem,
                                                         input logic [NUM_W-1:0] nq,
                                                         input logic [DEN_W-1:0] den);
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   d;
        logic [DEN_W-1:0] r;
        logic             q;
        t = {rem, nq[NUM_W-1]};
        r = t[DEN_W-1:0];
        q = 1'b0;
        if (t >= {1'b0, den}) begin
            d = t - {1'b0, den};
            r = d[DEN_W-1:0];
            q = 1'b1;
        end
        return {r, nq[NUM_W-2:0], q};
    endfunction

    function automatic t_dst div_step(input t_dst s);
        t_dst o;
        o = s;
        {o.rem_a, o.nq_a} = lane_step(s.rem_a, s.nq_a, s.den);
        {o.rem_b, o.nq_b} = lane_step(s.rem_b, s.nq_b, s.den);
        return o;
    endfunction

    logic [31:0] r_render_cmd;

    logic  r_s1_valid, r_s2_valid, r_s3_valid, r_seq_valid;
    t_tri  r_s1;
    t_s2   r_s2, n_s2;
    t_s3   r_s3, n_s3, r_seq;
    logic [IDX_W-1:0] r_seq_k;
    t_op   n_op;
    t_dst  n_dst0;
    t_dst  r_div [0:NUM_W];
    logic  r_out_valid;
    t_wr   r_out, n_out;

    logic  adv, seq_last, seq_free, seq_load, en1, en2, en3;

    // ---------------- Configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RENDER_CMD) ? r_render_cmd : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_render_cmd <= 32'd0;
        end else if (psel && penable && pwrite && paddr == ADDR_RENDER_CMD) begin
            r_render_cmd <= pwdata;
        end
    end

    // ---------------- Flow control ----------------
    // The back end moves as one block whenever the output register can take a beat.
    assign adv      = !r_out_valid || !i_stall;
    assign seq_last = r_seq.err || (r_seq_k == K_LAST);
    assign seq_free = !r_seq_valid || seq_last;
    assign seq_load = adv && seq_free;
    // Front stages compress bubbles so a waiting triangle sits right at the sequencer.
    assign en3      = !r_s3_valid || seq_load;
    assign en2      = !r_s2_valid || en3;
    assign en1      = !r_s1_valid || en2;
    assign o_stall  = !en1;

    // ---------------- Stage two: differences and area products ----------------
    always_comb begin
        logic signed [DIFF_W-1:0] sx1, sx2, sx3, sy1, sy2, sy3;
        sx1 = $signed({1'b0, r_s1.vert0_x});
        sy1 = $signed({1'b0, r_s1.vert0_y});
        sx2 = $signed({1'b0, r_s1.vert1_x});
        sy2 = $signed({1'b0, r_s1.vert1_y});
        sx3 = $signed({1'b0, r_s1.vert2_x});
        sy3 = $signed({1'b0, r_s1.vert2_y});
        n_s2.x1 = r_s1.vert0_x;
        n_s2.y1 = r_s1.vert0_y;
        n_s2.x2 = r_s1.vert1_x;
        n_s2.y2 = r_s1.vert1_y;
        n_s2.x3 = r_s1.vert2_x;
        n_s2.y3 = r_s1.vert2_y;
        n_s2.rgb0 = r_s1.vert0_rgb;
        n_s2.rgb1 = r_s1.vert1_rgb;
        n_s2.rgb2 = r_s1.vert2_rgb;
        n_s2.p1 = (sx1 - sx3) * (sy2 - sy3);
        n_s2.p2 = (sx2 - sx3) * (sy1 - sy3);
        // Equal y values count as unsorted: both divide by a zero height.
        n_s2.order_bad = !((r_s1.vert0_y < r_s1.vert1_y) && (r_s1.vert1_y < r_s1.vert2_y));
    end

    // ---------------- Stage three: area, color differences, numerators ----------------
    always_comb begin
        logic signed [DIFF_W-1:0] sx1, sx2, sx3, sy1, sy2, sy3, dy23, dy13;
        logic [COL_W-1:0]         ca, cb, cc;
        logic signed [DENS_W-1:0] sa, sb, sc, d13, d23, dca;
        logic signed [NUMS_W:0]   pr1, pr2;
        sx1 = $signed({1'b0, r_s2.x1});
        sx2 = $signed({1'b0, r_s2.x2});
        sx3 = $signed({1'b0, r_s2.x3});
        sy1 = $signed({1'b0, r_s2.y1});
        sy2 = $signed({1'b0, r_s2.y2});
        sy3 = $signed({1'b0, r_s2.y3});
        dy23 = sy2 - sy3;
        dy13 = sy1 - sy3;
        n_s3.area = DENS_W'(r_s2.p1) - DENS_W'(r_s2.p2);
        n_s3.err  = r_s2.order_bad || (n_s3.area == '0);
        for (int ch = 0; ch < 3; ch++) begin
            ca = {r_s2.rgb0[16-8*ch +: CHAN_W], {CFRAC{1'b0}}};
            cb = {r_s2.rgb1[16-8*ch +: CHAN_W], {CFRAC{1'b0}}};
            cc = {r_s2.rgb2[16-8*ch +: CHAN_W], {CFRAC{1'b0}}};
            sa = $signed({2'b00, ca});
            sb = $signed({2'b00, cb});
            sc = $signed({2'b00, cc});
            d13 = sa - sc;
            d23 = sb - sc;
            dca = sc - sa;
            pr1 = d13 * dy23;
            pr2 = d23 * dy13;
            n_s3.col[ch]    = ca;
            n_s3.num_dy[ch] = NUMS_W'(dca);
            n_s3.num_t1[ch] = pr1[NUMS_W-1:0];
            n_s3.num_t2[ch] = pr2[NUMS_W-1:0];
        end
        n_s3.dy31  = sy3 - sy1;
        n_s3.dy21  = sy2 - sy1;
        n_s3.dy32  = sy3 - sy2;
        n_s3.x1    = r_s2.x1;
        n_s3.x2    = r_s2.x2;
        n_s3.y1    = r_s2.y1;
        n_s3.fxd31 = {sx3 - sx1, {FX_SHIFT{1'b0}}};
        n_s3.fxd21 = {sx2 - sx1, {FX_SHIFT{1'b0}}};
        n_s3.fxd32 = {sx3 - sx2, {FX_SHIFT{1'b0}}};
    end

    // ---------------- Sequencer: one operation per write slot ----------------
    always_comb begin
        logic [1:0] ch_start, ch_dy, ch_dx;
        ch_start = r_seq_k[1:0];
        ch_dy    = 2'(r_seq_k - REG_DRDY_DOM);
        ch_dx    = 2'(r_seq_k - REG_DRDX);
        n_op.valid = r_seq_valid;
        n_op.idx   = gts_reg_index(r_seq_k);
        n_op.last  = (r_seq_k == K_LAST);
        n_op.err   = 1'b0;
        n_op.isdiv = 1'b0;
        n_op.pass  = '0;
        n_op.numa  = '0;
        n_op.numb  = '0;
        n_op.den   = DENS_W'(1);
        case (r_seq_k) inside
            REG_RSTART, REG_GSTART, REG_BSTART: begin
                n_op.pass = $signed(VAL_W'(r_seq.col[ch_start]));
            end
            REG_DRDY_DOM, REG_DGDY_DOM, REG_DBDY_DOM: begin
                n_op.isdiv = 1'b1;
                n_op.numa  = $signed(r_seq.num_dy[ch_dy]);
                n_op.den   = DENS_W'(r_seq.dy31);
            end
            REG_DRDX, REG_DGDX, REG_DBDX: begin
                n_op.isdiv = 1'b1;
                n_op.numa  = $signed(r_seq.num_t1[ch_dx]);
                n_op.numb  = $signed(r_seq.num_t2[ch_dx]);
                n_op.den   = r_seq.area;
            end
            REG_START_X_DOM, REG_START_X_SUB: begin
                n_op.pass = $signed(VAL_W'({r_seq.x1, {FX_SHIFT{1'b0}}}));
            end
            REG_DX_DOM: begin
                n_op.isdiv = 1'b1;
                n_op.numa  = NUMS_W'(r_seq.fxd31);
                n_op.den   = DENS_W'(r_seq.dy31);
            end
            REG_DX_SUB: begin
                n_op.isdiv = 1'b1;
                n_op.numa  = NUMS_W'(r_seq.fxd21);
                n_op.den   = DENS_W'(r_seq.dy21);
            end
            REG_START_Y: begin
                n_op.pass = $signed(VAL_W'({r_seq.y1, {FX_SHIFT{1'b0}}}));
            end
            REG_DY: begin
                n_op.pass = $signed(VAL_W'(1) <<< FX_SHIFT);
            end
            REG_COUNT: begin
                n_op.pass = VAL_W'(r_seq.dy21);
            end
            REG_RENDER: begin
                n_op.pass = $signed(r_render_cmd);
            end
            SLOT_SUB_X2: begin
                n_op.pass = $signed(VAL_W'({r_seq.x2, {FX_SHIFT{1'b0}}}));
            end
            SLOT_SUB_DX2: begin
                n_op.isdiv = 1'b1;
                n_op.numa  = NUMS_W'(r_seq.fxd32);
                n_op.den   = DENS_W'(r_seq.dy32);
            end
            SLOT_COUNT2: begin
                n_op.pass = VAL_W'(r_seq.dy32);
            end
            default: begin
            end
        endcase
        // A rejected triangle gives a single error write and nothing else.
        if (r_seq.err) begin
            n_op.idx   = REG_RSTART;
            n_op.last  = 1'b1;
            n_op.err   = 1'b1;
            n_op.isdiv = 1'b0;
            n_op.pass  = '0;
            n_op.numa  = '0;
            n_op.numb  = '0;
            n_op.den   = DENS_W'(1);
        end
    end

    // ---------------- Divider entry: signs split from magnitudes ----------------
    always_comb begin
        logic [NUMS_W-1:0] ma, mb;
        logic [DENS_W-1:0] md;
        ma = n_op.numa[NUMS_W-1] ? NUMS_W'(-n_op.numa) : NUMS_W'(n_op.numa);
        mb = n_op.numb[NUMS_W-1] ? NUMS_W'(-n_op.numb) : NUMS_W'(n_op.numb);
        md = n_op.den[DENS_W-1]  ? DENS_W'(-n_op.den)  : DENS_W'(n_op.den);
        n_dst0.valid = n_op.valid;
        n_dst0.idx   = n_op.idx;
        n_dst0.last  = n_op.last;
        n_dst0.err   = n_op.err;
        n_dst0.isdiv = n_op.isdiv;
        n_dst0.pass  = n_op.pass;
        n_dst0.neg_a = n_op.numa[NUMS_W-1] ^ n_op.den[DENS_W-1];
        n_dst0.neg_b = n_op.numb[NUMS_W-1] ^ n_op.den[DENS_W-1];
        n_dst0.den   = md[DEN_W-1:0];
        n_dst0.rem_a = '0;
        n_dst0.nq_a  = ma[NUM_W-1:0];
        n_dst0.rem_b = '0;
        n_dst0.nq_b  = mb[NUM_W-1:0];
    end

    // ---------------- Output: signed quotients combined and wrapped ----------------
    always_comb begin
        logic signed [NUMS_W-1:0] qa, qb, diff;
        qa = $signed({2'b00, r_div[NUM_W].nq_a});
        qb = $signed({2'b00, r_div[NUM_W].nq_b});
        if (r_div[NUM_W].neg_a) begin
            qa = -qa;
        end
        if (r_div[NUM_W].neg_b) begin
            qb = -qb;
        end
        diff = qa - qb;
        n_out.reg_index   = r_div[NUM_W].idx;
        n_out.reg_value   = r_div[NUM_W].isdiv ? $signed(diff[VAL_W-1:0]) : r_div[NUM_W].pass;
        n_out.last_write  = r_div[NUM_W].last;
        n_out.setup_error = r_div[NUM_W].err;
    end

    // ---------------- Registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_seq_valid <= 1'b0;
            r_seq_k     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i <= NUM_W; i++) begin
                r_div[i].valid <= 1'b0;
            end
        end else begin
            if (en1) begin
                r_s1_valid <= i_valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (adv) begin
                if (seq_free) begin
                    r_seq_valid <= r_s3_valid;
                    r_seq_k     <= '0;
                end else begin
                    r_seq_k <= r_seq_k + 1'b1;
                end
                r_div[0] <= n_dst0;
                for (int i = 1; i <= NUM_W; i++) begin
                    r_div[i] <= div_step(r_div[i-1]);
                end
                r_out_valid <= r_div[NUM_W].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= i_tri;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_s3 <= n_s3;
        end
        if (seq_load) begin
            r_seq <= r_s3;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_wr    = r_out;

endmodule

@@ rtl/gts_checker.sv @@
// Port-level checker for the Gouraud triangle setup block and its bind.
module gts_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input gts_pkg::t_wr   o_wr
);
    import gts_pkg::*;

    // An error beat is a single, final, all-zero write.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wr.setup_error |->
            o_wr.last_write && o_wr.reg_index == REG_RSTART && o_wr.reg_value == 0)
        else $error("error beat is not a single zero write");

    // A good triangle always ends on the continue command.
    a_last_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wr.last_write && !o_wr.setup_error |-> o_wr.reg_index == REG_CONTINUE)
        else $error("last write of a triangle is not the continue command");

    // The continue command is never written before the end of a triangle.
    a_continue_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wr.reg_index == REG_CONTINUE |-> o_wr.last_write)
        else $error("continue command written mid-triangle");

    // A stalled write beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_wr))
        else $error("stalled write beat changed");

endmodule

bind gouraud_triangle_setup_top gts_checker u_gts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_wr    (o_wr)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the Gouraud triangle setup block: triangle beats in, write beats out.
module tb_top;
    import gts_pkg::*;

    // The cycle limit allows far more than the slowest correct run: about three hundred
    // triangles of twenty writes each, heavy stalls on both sides, and the divider latency.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles of quiet after the last expected write before the render command changes,
    // or before the run ends. This is well past the time a write takes through the pipe.
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_PER_PHASE = 75;

    // Predicts the write beats of each accepted triangle and checks the beats in order.
    class write_scoreboard;
        t_wr expected_q[$];
        int  errors;

        function new();
            errors = 0;
        endfunction

        function longint wrap32(longint v);
            return longint'(int'(v));
        endfunction

        function void note_triangle(t_tri t, logic [31:0] cmd);
            longint x1, y1, x2, y2, x3, y3;
            longint area, dy31, dy21, dy32;
            longint ca, cb, cc, d13, d23, t1, t2;
            longint vals[20];
            logic [IDX_W-1:0] regs[20];
            t_wr w;
            int pos;
            regs = '{REG_RSTART, REG_GSTART, REG_BSTART, REG_DRDY_DOM, REG_DGDY_DOM,
                     REG_DBDY_DOM, REG_DRDX, REG_DGDX, REG_DBDX, REG_START_X_DOM,
                     REG_DX_DOM, REG_START_X_SUB, REG_DX_SUB, REG_START_Y, REG_DY,
                     REG_COUNT, REG_RENDER, REG_START_X_SUB, REG_DX_SUB, REG_CONTINUE};
            x1 = longint'(t.vert0_x);
            y1 = longint'(t.vert0_y);
            x2 = longint'(t.vert1_x);
            y2 = longint'(t.vert1_y);
            x3 = longint'(t.vert2_x);
            y3 = longint'(t.vert2_y);
            area = wrap32((x1 - x3) * (y2 - y3) - (x2 - x3) * (y1 - y3));
            // Unsorted, flat-topped or flat-bottomed, or degenerate: one error beat.
            if (y1 >= y2 || y2 >= y3 || area == 0) begin
                w.reg_index = REG_RSTART;
                w.reg_value = '0;
                w.last_write = 1'b1;
                w.setup_error = 1'b1;
                expected_q.push_back(w);
                return;
            end
            dy31 = y3 - y1;
            dy21 = y2 - y1;
            dy32 = y3 - y2;
            for (int ch = 0; ch < 3; ch++) begin
                pos = 16 - 8 * ch;
                ca = longint'((t.vert0_rgb >> pos) & 24'hff) << CFRAC;
                cb = longint'((t.vert1_rgb >> pos) & 24'hff) << CFRAC;
                cc = longint'((t.vert2_rgb >> pos) & 24'hff) << CFRAC;
                vals[ch] = ca;
                vals[3 + ch] = wrap32(wrap32(cc - ca) / dy31);
                d13 = wrap32(ca - cc);
                d23 = wrap32(cb - cc);
                t1 = (d13 * (y2 - y3)) / area;
                t2 = (d23 * (y1 - y3)) / area;
                vals[6 + ch] = wrap32(t1 - t2);
            end
            vals[9] = wrap32(x1 * 65536);
            vals[10] = wrap32(wrap32((x3 - x1) * 65536) / dy31);
            vals[11] = wrap32(x1 * 65536);
            vals[12] = wrap32(wrap32((x2 - x1) * 65536) / dy21);
            vals[13] = wrap32(y1 * 65536);
            vals[14] = 65536;
            vals[15] = dy21;
            vals[16] = longint'(cmd);
            vals[17] = wrap32(x2 * 65536);
            vals[18] = wrap32(wrap32((x3 - x2) * 65536) / dy32);
            vals[19] = dy32;
            for (int k = 0; k < 20; k++) begin
                w.reg_index = regs[k];
                w.reg_value = vals[k][31:0];
                w.last_write = (k == 19);
                w.setup_error = 1'b0;
                expected_q.push_back(w);
            end
        endfunction

        function void report(string field, longint exp_v, longint got_v);
            errors++;
            $display("%0t mismatch on %s: expected %0h, actual %0h",
                     $time, field, exp_v, got_v);
        endfunction

        function void check_write(t_wr got);
            t_wr exp_w;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected write beat: expected none, actual %0h",
                         $time, got);
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.reg_index !== exp_w.reg_index)
                report("reg_index", longint'(exp_w.reg_index), longint'(got.reg_index));
            if (got.reg_value !== exp_w.reg_value)
                report("reg_value", longint'(exp_w.reg_value[31:0]),
                       longint'(got.reg_value[31:0]));
            if (got.last_write !== exp_w.last_write)
                report("last_write", longint'(exp_w.last_write), longint'(got.last_write));
            if (got.setup_error !== exp_w.setup_error)
                report("setup_error", longint'(exp_w.setup_error),
                       longint'(got.setup_error));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_tri               i_tri;
    logic               o_valid;
    logic               i_stall;
    t_wr                o_wr;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    write_scoreboard sb;
    logic [31:0]     render_cmd;
    int              send_idle_pct;
    int              stall_pct;
    int              cycles;

    gouraud_triangle_setup_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_tri   (i_tri),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_wr    (o_wr),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The cycle counter is the only timeout. A hung block or a lost write ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL gouraud_triangle_setup_top");
            $finish;
        end
    end

    // Write side: check every accepted beat against the oldest prediction, then pick
    // the stall for the next cycle. The stall is a fresh draw each cycle, so it lands
    // on every phase of the twenty-write run and of the divider pipe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_write(o_wr);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Writes the render command through the register port: a setup cycle, then an
    // access cycle. pready is always high, so the write lands at the access edge.
    task automatic write_render_cmd(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_RENDER_CMD;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        render_cmd = value;
    endtask

    // Sends one triangle beat. Valid stays high from one beat to the next unless an
    // idle gap is drawn, so it is never lowered and raised within the same step.
    task automatic send_triangle(t_tri t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_tri <= t;
        do @(posedge i_clk); while (o_stall);
        sb.note_triangle(t, render_cmd);
    endtask

    // The render command may only change while the block is quiet, so wait until
    // every predicted write has come back and the pipe has had time to empty.
    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_tri make_tri(int x0, int y0, int c0, int x1, int y1, int c1,
                                      int x2, int y2, int c2);
        t_tri t;
        t.vert0_x = COORD_W'(x0);
        t.vert0_y = COORD_W'(y0);
        t.vert0_rgb = RGB_W'(c0);
        t.vert1_x = COORD_W'(x1);
        t.vert1_y = COORD_W'(y1);
        t.vert1_rgb = RGB_W'(c1);
        t.vert2_x = COORD_W'(x2);
        t.vert2_y = COORD_W'(y2);
        t.vert2_rgb = RGB_W'(c2);
        return t;
    endfunction

    // Most random triangles are properly sorted with distinct y values, so they reach
    // the full setup path; the rest are raw noise, which is mostly rejected.
    function automatic t_tri random_tri();
        t_tri t;
        int ya, yb, yc;
        t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        if ($urandom_range(99) < 85) begin
            if ($urandom_range(3) == 0) begin
                // Short triangles: small y steps stress the slope divides.
                ya = $urandom_range(2040);
                yb = ya + $urandom_range(1, 3);
                yc = yb + $urandom_range(1, 3);
            end else begin
                ya = $urandom_range(2045);
                yb = $urandom_range(ya + 1, 2046);
                yc = $urandom_range(yb + 1, 2047);
            end
            t.vert0_y = COORD_W'(ya);
            t.vert1_y = COORD_W'(yb);
            t.vert2_y = COORD_W'(yc);
        end
        return t;
    endfunction

    initial begin
        t_tri directed[$];
        logic [31:0] cmds[4];
        int idle_set[4];
        int stall_set[4];

        sb = new();
        render_cmd = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_tri <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of position and color, both signs of area, every rejection case.
        directed.push_back(make_tri(0, 0, 0, 2047, 1, 24'hffffff, 0, 2047, 0));
        directed.push_back(make_tri(2047, 0, 24'hffffff, 0, 1024, 0, 2047, 2047, 24'hffffff));
        directed.push_back(make_tri(0, 0, 24'hff0000, 2047, 1024, 24'h00ff00,
                                    0, 2047, 24'h0000ff));
        directed.push_back(make_tri(2047, 0, 24'h0000ff, 0, 1024, 24'hff0000,
                                    2047, 2047, 24'h00ff00));
        directed.push_back(make_tri(0, 0, 24'h808080, 2047, 1, 24'h7f7f7f, 0, 2, 24'h010101));
        directed.push_back(make_tri(1000, 1000, 24'h123456, 1001, 1001, 24'hfedcba,
                                    1000, 1002, 24'h00ff00));
        directed.push_back(make_tri(2047, 2045, 24'hffffff, 0, 2046, 0, 2047, 2047, 0));
        // Top vertex below the middle one.
        directed.push_back(make_tri(5, 10, 24'h111111, 5, 3, 24'h222222, 9, 20, 24'h333333));
        // Middle vertex below the bottom one.
        directed.push_back(make_tri(0, 0, 24'h111111, 1, 50, 24'h222222, 2, 40, 24'h333333));
        // Flat top and flat bottom: a zero y step.
        directed.push_back(make_tri(0, 7, 24'hffffff, 100, 7, 0, 50, 90, 24'h00ff00));
        directed.push_back(make_tri(0, 7, 24'hffffff, 100, 60, 0, 50, 60, 24'h00ff00));
        directed.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_tri(2047, 2047, 24'hffffff, 2047, 2047, 24'hffffff,
                                    2047, 2047, 24'hffffff));
        // Collinear vertices give a zero area.
        directed.push_back(make_tri(0, 0, 24'hff00ff, 10, 10, 0, 20, 20, 24'hffffff));
        directed.push_back(make_tri(300, 100, 24'h00ff00, 300, 500, 0, 300, 900, 24'hff0000));

        // Each phase sets a new render command, the extremes among them, then a mix of
        // idling: none, sender gaps, write-side stalls, and both at once.
        cmds = '{32'h0000_0000, 32'hffff_ffff, $urandom, 32'h8000_0000};
        idle_set = '{0, 56, 0, 38};
        stall_set = '{0, 0, 56, 38};
        for (int ph = 0; ph < 4; ph++) begin
            write_render_cmd(cmds[ph]);
            send_idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0)
                foreach (directed[i])
                    send_triangle(directed[i]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_triangle(random_tri());
            i_valid <= 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("PASS gouraud_triangle_setup_top");
        else
            $display("FAIL gouraud_triangle_setup_top");
        $finish;
    end

endmodule
